@@ hw/rtl/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder package
// Shared constants, payload types and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_LEN       = 1024;
  localparam int STATE_CAP     = 2 * MAX_LEN + 2;
  localparam int ST_W          = 12;
  localparam int LEN_W         = 11;
  localparam int SYM_W         = 5;
  localparam int ROW           = 1 << SYM_W;
  localparam int TA_W          = ST_W + SYM_W;
  localparam int TDEPTH        = STATE_CAP * ROW;

  typedef struct packed {
    logic [4:0] symbol;
    logic       restart;
  } sab_in_t;

  typedef struct packed {
    logic [11:0] state_index;
    logic [10:0] state_length;
    logic [11:0] link_index;
    logic        clone_made;
    logic [11:0] clone_index;
    logic [11:0] states_used;
    logic        full_flag;
  } sab_out_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             restart;
    logic             sym_ok;
  } sab_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/sab_front.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder front end
// Accepts items, classifies the symbol and queues commands for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sab_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sab_pkg::sab_in_t in_data,
  output logic                  cmd_valid,
  output sab_pkg::sab_cmd_t     cmd,
  input  wire logic             cmd_pop
);
  import sab_pkg::*;

  sab_cmd_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  sab_cmd_t   ent;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;

  always_comb begin
    ent.sym     = in_data.symbol;
    ent.restart = in_data.restart;
    ent.sym_ok  = ({27'd0, in_data.symbol} < ALPHABET_SIZE);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sab_engine.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder engine
// Sequencer over the transition, link and length memories; holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sab_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire sab_pkg::sab_cmd_t cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sab_pkg::sab_out_t      out_data
);
  import sab_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CHK, S_ZERO, S_W1, S_W2, S_W3, S_CLN,
    S_COPY, S_R1, S_R2, S_QL, S_LINK, S_OUT
  } st_t;

  logic [ST_W-1:0]  tmem [0:TDEPTH-1];
  logic [ST_W-1:0]  lmem [0:STATE_CAP-1];
  logic [ST_W-1:0]  nmem [0:STATE_CAP-1];
  logic [ST_W-1:0]  t_rd, l_rd, n_rd;

  logic             t_we, l_we, n_we;
  logic [TA_W-1:0]  t_wa, t_ra;
  logic [ST_W-1:0]  l_wa, l_ra, n_wa, n_ra;
  logic [ST_W-1:0]  t_wd, l_wd, n_wd;

  st_t              st_r, st_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             init_r, init_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             ok_r, ok_nxt;
  logic [ST_W-1:0]  last_r, last_nxt, count_r, count_nxt, cur_r, cur_nxt;
  logic [LEN_W-1:0] lastlen_r, lastlen_nxt, curlen_r, curlen_nxt;
  logic [ST_W-1:0]  p_r, p_nxt, q_r, q_nxt, clone_r, clone_nxt;
  logic [ST_W-1:0]  lenp_r, lenp_nxt, lv_r, lv_nxt;
  logic             made_r, made_nxt, full_r, full_nxt;
  logic             ov_r, ov_nxt;
  sab_out_t         o_r, o_nxt;
  logic             is_full;

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_wa] <= t_wd;
    t_rd <= tmem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_wa] <= l_wd;
    l_rd <= lmem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (n_we) nmem[n_wa] <= n_wd;
    n_rd <= nmem[n_ra];
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;
  assign is_full   = ({21'd0, lastlen_r} >= MAX_LEN) ||
                     ({20'd0, count_r} + 32'd2 > STATE_CAP);

  always_comb begin
    st_nxt = st_r;  cnt_nxt = cnt_r;  init_nxt = init_r;
    sym_nxt = sym_r;  ok_nxt = ok_r;  last_nxt = last_r;  count_nxt = count_r;
    cur_nxt = cur_r;  lastlen_nxt = lastlen_r;  curlen_nxt = curlen_r;
    p_nxt = p_r;  q_nxt = q_r;  clone_nxt = clone_r;  lenp_nxt = lenp_r;
    lv_nxt = lv_r;  made_nxt = made_r;  full_nxt = full_r;
    o_nxt = o_r;  ov_nxt = ov_r && !out_ready;
    cmd_pop = 1'b0;
    t_we = 1'b0;  t_wa = '0;  t_wd = '0;  t_ra = '0;
    l_we = 1'b0;  l_wa = '0;  l_wd = '0;  l_ra = '0;
    n_we = 1'b0;  n_wa = '0;  n_wd = '0;  n_ra = '0;
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          sym_nxt = cmd.sym;
          ok_nxt  = cmd.sym_ok;
          cnt_nxt = '0;
          st_nxt  = cmd.restart ? S_CLR : S_CHK;
        end
      end
      S_CLR: begin
        t_we = 1'b1;
        t_wa = {{(ST_W-1){1'b0}}, cnt_r[SYM_W], cnt_r[SYM_W-1:0]};
        if (cnt_r == 7'd0) begin
          l_we = 1'b1;  l_wa = '0;
          n_we = 1'b1;  n_wa = '0;  n_wd = '1;
        end else if (cnt_r == 7'd1) begin
          l_we = 1'b1;  l_wa = 12'd1;
          n_we = 1'b1;  n_wa = 12'd1;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(2 * ROW - 1)) begin
          last_nxt    = 12'd1;
          lastlen_nxt = '0;
          count_nxt   = 12'd2;
          init_nxt    = 1'b0;
          st_nxt      = init_r ? S_IDLE : S_CHK;
        end
      end
      S_CHK: begin
        cur_nxt = '0;  curlen_nxt = '0;  lv_nxt = '0;  clone_nxt = '0;
        made_nxt = 1'b0;  full_nxt = 1'b0;  cnt_nxt = '0;
        if (is_full) begin
          full_nxt = 1'b1;
          st_nxt   = S_OUT;
        end else if (!ok_r) begin
          st_nxt = S_OUT;
        end else begin
          cur_nxt    = count_r;
          count_nxt  = count_r + 12'd1;
          curlen_nxt = lastlen_r + 11'd1;
          n_we = 1'b1;  n_wa = count_r;  n_wd = {1'b0, lastlen_r + 11'd1};
          p_nxt  = last_r;
          st_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        t_we = 1'b1;  t_wa = {cur_r, cnt_r[SYM_W-1:0]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(ROW - 1)) st_nxt = S_W1;
      end
      S_W1: begin
        if (p_r == '0) begin
          lv_nxt = 12'd1;
          st_nxt = S_LINK;
        end else begin
          t_ra = {p_r, sym_r};  l_ra = p_r;  n_ra = p_r;
          st_nxt = S_W2;
        end
      end
      S_W2: begin
        lenp_nxt = n_rd;
        if (t_rd == '0) begin
          t_we = 1'b1;  t_wa = {p_r, sym_r};  t_wd = cur_r;
          p_nxt  = l_rd;
          st_nxt = S_W1;
        end else begin
          q_nxt  = t_rd;
          n_ra   = t_rd;
          st_nxt = S_W3;
        end
      end
      S_W3: begin
        if (lenp_r + 12'd1 == n_rd) begin
          lv_nxt = q_r;
          st_nxt = S_LINK;
        end else begin
          clone_nxt = count_r;
          count_nxt = count_r + 12'd1;
          made_nxt  = 1'b1;
          n_we = 1'b1;  n_wa = count_r;  n_wd = lenp_r + 12'd1;
          l_ra   = q_r;
          st_nxt = S_CLN;
        end
      end
      S_CLN: begin
        l_we = 1'b1;  l_wa = clone_r;  l_wd = l_rd;
        cnt_nxt = '0;
        st_nxt  = S_COPY;
      end
      S_COPY: begin
        t_ra = {q_r, cnt_r[SYM_W-1:0]};
        if (cnt_r != 7'd0) begin
          t_we = 1'b1;
          t_wa = {clone_r, 5'(cnt_r - 7'd1)};
          t_wd = t_rd;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(ROW)) st_nxt = S_R1;
      end
      S_R1: begin
        if (p_r == '0) begin
          st_nxt = S_QL;
        end else begin
          t_ra = {p_r, sym_r};  l_ra = p_r;
          st_nxt = S_R2;
        end
      end
      S_R2: begin
        if (t_rd == q_r) begin
          t_we = 1'b1;  t_wa = {p_r, sym_r};  t_wd = clone_r;
          p_nxt  = l_rd;
          st_nxt = S_R1;
        end else begin
          st_nxt = S_QL;
        end
      end
      S_QL: begin
        l_we = 1'b1;  l_wa = q_r;  l_wd = clone_r;
        lv_nxt = clone_r;
        st_nxt = S_LINK;
      end
      S_LINK: begin
        l_we = 1'b1;  l_wa = cur_r;  l_wd = lv_r;
        last_nxt    = cur_r;
        lastlen_nxt = curlen_r;
        st_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          o_nxt.state_index  = cur_r;
          o_nxt.state_length = curlen_r;
          o_nxt.link_index   = lv_r;
          o_nxt.clone_made   = made_r;
          o_nxt.clone_index  = clone_r;
          o_nxt.states_used  = count_r;
          o_nxt.full_flag    = full_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      init_r  <= 1'b1;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      last_r  <= 12'd1;
      count_r <= 12'd2;
      lastlen_r <= '0;
    end else begin
      st_r      <= st_nxt;
      init_r    <= init_nxt;
      cnt_r     <= cnt_nxt;
      ov_r      <= ov_nxt;
      last_r    <= last_nxt;
      count_r   <= count_nxt;
      lastlen_r <= lastlen_nxt;
    end
    sym_r <= sym_nxt;  ok_r <= ok_nxt;  cur_r <= cur_nxt;  curlen_r <= curlen_nxt;
    p_r <= p_nxt;  q_r <= q_nxt;  clone_r <= clone_nxt;  lenp_r <= lenp_nxt;
    lv_r <= lv_nxt;  made_r <= made_nxt;  full_r <= full_nxt;  o_r <= o_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/suffix_automaton_builder_unit.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder
// Online suffix automaton construction, one symbol per transfer.
//
//   channel  direction  payload    handshake
//   in_      input      sab_in_t   in_valid / in_ready
//   out_     output     sab_out_t  out_valid / out_ready
//
// A symbol clears the new row, then walks suffix links, setting a transition at
// each step, until the walk ends. A clone copies the row of the target state and
// then redirects transitions to the clone; a refused or ignored symbol goes
// straight to its result. A restart adds a clear of the first two rows, and the
// same clear runs after reset before the first item.
// A two-entry queue lets the input side keep taking transfers while a result
// waits on out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suffix_automaton_builder_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sab_pkg::sab_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sab_pkg::sab_out_t      out_data
);
  import sab_pkg::*;

  logic     cmd_valid, cmd_pop;
  sab_cmd_t cmd;

  sab_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd, .cmd_pop
  );

  sab_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop,
    .out_valid, .out_ready, .out_data
  );

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_flag |-> out_data.state_index == '0 &&
      !out_data.clone_made)
    else $error("refused symbol reports a state");

  a_clone_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clone_made |->
      out_data.clone_index == out_data.state_index + 12'd1 &&
      out_data.link_index == out_data.clone_index)
    else $error("clone index or link inconsistent");

  a_new_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.state_index != '0 |->
      out_data.link_index != '0 && out_data.state_length != '0)
    else $error("new state without link or length");

endmodule

`default_nettype wire
